FILE: design/multi_car_elevator_sweep_top_assert.svh
// Assertion macros for the elevator sweep controller checker.
// Needs a clock named clk and a reset named rst in the scope of use.
`ifndef MULTI_CAR_ELEVATOR_SWEEP_TOP_ASSERT_SVH
`define MULTI_CAR_ELEVATOR_SWEEP_TOP_ASSERT_SVH

// same-cycle implication
`define MCES_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// next-cycle implication
`define MCES_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

FILE: design/mces_pkg.sv
// Shared constants and types for the elevator sweep controller.
// No dependencies.
package mces_pkg;

  localparam int NUM_CARS   = 4;
  localparam int NUM_FLOORS = 16;

  localparam int CAR_AW     = (NUM_CARS > 1) ? $clog2(NUM_CARS) : 1;
  localparam int FLR_AW     = $clog2(NUM_FLOORS);
  localparam int STOP_DEPTH = NUM_CARS * NUM_FLOORS;
  localparam int STOP_AW    = $clog2(STOP_DEPTH);

  localparam logic [3:0] STOP_MAX  = 4'd15;
  localparam logic [5:0] WAIT_MAX  = 6'd63;
  localparam logic [3:0] CAP_RESET = 4'd10;

  typedef enum logic [1:0] {
    OP_HALL    = 2'd0,
    OP_CAR     = 2'd1,
    OP_SERVICE = 2'd2,
    OP_NOP     = 2'd3
  } op_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } st_t;

endpackage

FILE: design/multi_car_elevator_sweep_top.sv
// Elevator sweep controller: call counters in memories, car state in registers.
// Depends on mces_pkg.
//
// Per item, the transfer cycle issues registered reads of the stop-count and
// waiting-count memories, and the execute cycle modifies the counts, writes them
// back and loads the output register; no new item is taken until the execute cycle
// ends, for the memory read-modify-write. The next item is taken while a result
// still waits in the output register; a stalled output holds the execute cycle
// until the register frees. Valid bits per memory entry stand for the reset clear,
// so no clearing pass runs after reset.
module multi_car_elevator_sweep_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [3:0] cfg_data,      // car_capacity
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,       // car[1:0], floor[5:2], going_up[6], zero[7]
  input  logic [1:0] s_tuser,       // op[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata       // car_floor[3:0], car_heading_up[4], car_load[8:5],
                                    // alighted[12:9], boarded[16:13], saturated[17],
                                    // zero[23:18]
);
  import mces_pkg::*;

  st_t st, st_next;
  logic [3:0] cap;

  logic [FLR_AW-1:0] position [NUM_CARS];
  logic              heading  [NUM_CARS];
  logic [3:0]        load     [NUM_CARS];

  logic [3:0]  stop_mem [STOP_DEPTH];
  logic [11:0] wait_mem [NUM_FLOORS];   // down[11:6], up[5:0]
  logic [STOP_DEPTH-1:0] stop_vld;
  logic [NUM_FLOORS-1:0] wait_vld;

  logic [3:0]  stop_q;
  logic [11:0] wait_q;
  logic        stop_vq, wait_vq;

  op_t               r_op;
  logic [CAR_AW-1:0] r_car;
  logic [FLR_AW-1:0] r_faddr;
  logic [STOP_AW-1:0] r_saddr;
  logic              r_up, r_car_ok, r_floor_ok;

  logic               accept, fire;
  logic [1:0]         in_car;
  logic [3:0]         in_floor;
  logic [CAR_AW-1:0]  car_idx;
  logic [FLR_AW-1:0]  pos_sel, faddr;
  logic [STOP_AW-1:0] saddr;
  logic               car_ok, floor_ok;

  logic [3:0] stop_rd, room1, room2, n1, n2, ld, ld1, ld2, ld3, ld_out;
  logic [5:0] up_rd, dn_rd, up_new, dn_new;
  logic       hd, hd1, hd2, hd3, hd4, hd_out, sat;
  logic [FLR_AW-1:0] p, p_new, pos_out;
  logic       stop_we, wait_we, car_we;
  logic [3:0] stop_wd;
  logic [3:0] alighted, boarded;

  assign cfg_ready = !rst;
  assign s_tready  = (st == ST_IDLE) && !rst;
  assign accept    = s_tvalid && s_tready;
  assign fire      = (st == ST_EXEC) && (!m_tvalid || m_tready);

  assign in_car   = s_tdata[1:0];
  assign in_floor = s_tdata[5:2];
  assign car_idx  = CAR_AW'(in_car);
  assign car_ok   = 32'(in_car) < NUM_CARS;
  assign floor_ok = 32'(in_floor) < NUM_FLOORS;
  assign pos_sel  = (32'(position[car_idx]) >= NUM_FLOORS) ?
                    FLR_AW'(NUM_FLOORS - 1) : position[car_idx];
  assign faddr    = (op_t'(s_tuser) == OP_SERVICE) ? pos_sel : FLR_AW'(in_floor);
  assign saddr    = STOP_AW'(32'(car_idx) * NUM_FLOORS + 32'(faddr));

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_IDLE;
    end else begin
      st <= st_next;
    end
  end

  always_comb begin
    st_next = st;
    case (st)
      ST_IDLE: if (accept) st_next = ST_EXEC;
      ST_EXEC: if (fire) st_next = ST_IDLE;
      default: st_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap <= CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      cap <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      r_op       <= op_t'(s_tuser);
      r_car      <= car_idx;
      r_faddr    <= faddr;
      r_saddr    <= saddr;
      r_up       <= s_tdata[6];
      r_car_ok   <= car_ok;
      r_floor_ok <= floor_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stop_q <= stop_mem[saddr];
      wait_q <= wait_mem[faddr];
    end
    if (stop_we) stop_mem[r_saddr] <= stop_wd;
    if (wait_we) wait_mem[r_faddr] <= {dn_new, up_new};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stop_vld <= '0;
      wait_vld <= '0;
      stop_vq  <= 1'b0;
      wait_vq  <= 1'b0;
    end else begin
      if (accept) begin
        stop_vq <= stop_vld[saddr];
        wait_vq <= wait_vld[faddr];
      end
      if (stop_we) stop_vld[r_saddr] <= 1'b1;
      if (wait_we) wait_vld[r_faddr] <= 1'b1;
    end
  end

  always_comb begin
    stop_rd = stop_vq ? stop_q : 4'd0;
    up_rd   = wait_vq ? wait_q[5:0] : 6'd0;
    dn_rd   = wait_vq ? wait_q[11:6] : 6'd0;
    ld      = load[r_car];
    hd      = heading[r_car];
    p       = r_faddr;

    stop_we  = 1'b0;
    wait_we  = 1'b0;
    car_we   = 1'b0;
    stop_wd  = 4'd0;
    up_new   = up_rd;
    dn_new   = dn_rd;
    sat      = 1'b0;
    alighted = 4'd0;
    boarded  = 4'd0;

    // service step datapath
    ld1   = (ld > stop_rd) ? ld - stop_rd : 4'd0;
    room1 = (cap > ld1) ? cap - ld1 : 4'd0;
    n1    = 4'd0;
    hd1   = hd;
    if (hd || ld1 == 4'd0) begin
      n1 = (up_rd < {2'b00, room1}) ? up_rd[3:0] : room1;
      if (n1 != 4'd0 && ld1 == 4'd0) hd1 = 1'b1;
    end
    ld2   = ld1 + n1;
    room2 = (cap > ld2) ? cap - ld2 : 4'd0;
    n2    = 4'd0;
    hd2   = hd1;
    if (!hd1 || ld2 == 4'd0) begin
      n2 = (dn_rd < {2'b00, room2}) ? dn_rd[3:0] : room2;
      if (n2 != 4'd0 && ld2 == 4'd0) hd2 = 1'b0;
    end
    ld3 = ld2 + n2;
    if (p == '0) begin
      hd3 = 1'b1;
    end else if (p == FLR_AW'(NUM_FLOORS - 1)) begin
      hd3 = 1'b0;
    end else begin
      hd3 = hd2;
    end
    p_new = hd3 ? p + FLR_AW'(1) : p - FLR_AW'(1);
    hd4   = (p_new == '0 || p_new == FLR_AW'(NUM_FLOORS - 1)) ? !hd3 : hd3;

    pos_out = position[r_car];
    hd_out  = hd;
    ld_out  = ld;

    case (r_op)
      OP_HALL: begin
        if (r_floor_ok) begin
          if (r_up) begin
            sat     = (up_rd == WAIT_MAX);
            up_new  = up_rd + 6'd1;
            wait_we = fire && !sat;
          end else begin
            sat     = (dn_rd == WAIT_MAX);
            dn_new  = dn_rd + 6'd1;
            wait_we = fire && !sat;
          end
        end
      end
      OP_CAR: begin
        if (r_car_ok && r_floor_ok) begin
          sat     = (stop_rd == STOP_MAX);
          stop_wd = stop_rd + 4'd1;
          stop_we = fire && !sat;
        end
      end
      OP_SERVICE: begin
        if (r_car_ok) begin
          alighted = stop_rd;
          boarded  = n1 + n2;
          up_new   = up_rd - {2'b00, n1};
          dn_new   = dn_rd - {2'b00, n2};
          stop_wd  = 4'd0;
          stop_we  = fire;
          wait_we  = fire;
          car_we   = fire;
          pos_out  = p_new;
          hd_out   = hd4;
          ld_out   = ld3;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CARS; i++) begin
        position[i] <= '0;
        heading[i]  <= 1'b1;
        load[i]     <= 4'd0;
      end
    end else if (car_we) begin
      position[r_car] <= p_new;
      heading[r_car]  <= hd4;
      load[r_car]     <= ld3;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      m_tdata <= {6'd0, sat, boarded, alighted,
                  r_car_ok ? ld_out : 4'd0,
                  r_car_ok ? hd_out : 1'b0,
                  r_car_ok ? 4'(pos_out) : 4'd0};
    end
  end

endmodule

FILE: design/mces_checker.sv
// Port-level checker for the elevator sweep controller, bound to the top level.
// Depends on mces_pkg and multi_car_elevator_sweep_top_assert.svh.
`include "multi_car_elevator_sweep_top_assert.svh"

module mces_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata
);
  import mces_pkg::*;

  logic at_bottom, at_top;

  assign at_bottom = (m_tdata[3:0] == 4'd0);
  assign at_top    = (32'(m_tdata[3:0]) == NUM_FLOORS - 1);

  `MCES_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")
  `MCES_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready, "second item taken while busy")
  `MCES_ASSERT_NOW(a_end_heading, m_tvalid && (at_bottom || at_top), m_tdata[4] == at_bottom, "car heads out of the shaft")
  `MCES_ASSERT_NOW(a_board_load, m_tvalid, m_tdata[16:13] <= m_tdata[8:5], "boarded exceeds load")

endmodule

bind multi_car_elevator_sweep_top mces_checker u_mces_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
